// File: hw/rtl/conv1d_same_pad_forward_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef CONV1D_SAME_PAD_FORWARD_DEFINES_SVH
`define CONV1D_SAME_PAD_FORWARD_DEFINES_SVH

// same-cycle implication, masked during reset
`define C1D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c1d check failed");

// next-cycle implication, masked during reset
`define C1D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c1d check failed");

// next-cycle implication, also checked across reset
`define C1D_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c1d reset check failed");

`endif

// File: hw/rtl/c1d_pkg.sv
// Package for the 1D convolution block: field widths, codes, command type.
// No dependencies.
`default_nettype none
package c1d_pkg;
  localparam int CH_W  = 3;
  localparam int TAP_W = 2;
  localparam int VAL_W = 16;
  localparam int RES_W = 32;
  localparam int ACC_W = 48;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_SAMPLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CH_W-1:0]    out_channel;
    logic [CH_W-1:0]    in_channel;
    logic [TAP_W-1:0]   tap;
    logic [VAL_W-1:0]   value;
    logic               eos;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_BIAS,
    S_MAC,
    S_D1,
    S_D2,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/c1d_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on c1d_pkg.
`default_nettype none
interface c1d_item_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [c1d_pkg::CH_W-1:0]    out_channel;
  logic [c1d_pkg::CH_W-1:0]    in_channel;
  logic [c1d_pkg::TAP_W-1:0]   tap;
  logic signed [c1d_pkg::VAL_W-1:0] value;
  logic                        end_of_sequence;
  modport source (output valid, action, out_channel, in_channel, tap, value,
                  end_of_sequence, input ready);
  modport sink (input valid, action, out_channel, in_channel, tap, value,
                end_of_sequence, output ready);
endinterface

interface c1d_res_if;
  logic                        valid;
  logic                        ready;
  logic [c1d_pkg::CH_W-1:0]    channel_out;
  logic signed [c1d_pkg::RES_W-1:0] result;
  logic                        last;
  modport source (output valid, channel_out, result, last, input ready);
  modport sink (input valid, channel_out, result, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/c1d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module c1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/c1d_front.sv
// Front end: accepts items, drops ignored ones, queues commands for the back end.
// Depends on c1d_pkg and c1d_item_if.
`default_nettype none
module c1d_front #(
  parameter int IN_CHANNELS  = 8,
  parameter int OUT_CHANNELS = 8,
  parameter int TAPS         = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  c1d_item_if.sink         item,
  output c1d_pkg::q_head_t head,
  input  wire logic        pop
);
  import c1d_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);

  cmd_t            q [QUEUE_DEPTH];
  logic [QAW-1:0]  wptr;
  logic [QAW-1:0]  rptr;
  logic [QAW:0]    count;
  logic            keep;
  logic            push;
  cmd_t            cmd;

  assign item.ready = (count != (QAW+1)'(QUEUE_DEPTH));

  always_comb begin
    cmd.out_channel = item.out_channel;
    cmd.in_channel  = item.in_channel;
    cmd.tap         = item.tap;
    cmd.value       = item.value;
    cmd.eos         = item.end_of_sequence;
    cmd.kind        = CMD_SAMPLE;
    keep            = 1'b0;
    unique case (item.action)
      ACT_WEIGHT: begin
        cmd.kind = CMD_WEIGHT;
        keep = (int'(item.out_channel) < OUT_CHANNELS) &&
               (int'(item.in_channel) < IN_CHANNELS) && (int'(item.tap) < TAPS);
      end
      ACT_BIAS: begin
        cmd.kind = CMD_BIAS;
        keep = int'(item.out_channel) < OUT_CHANNELS;
      end
      ACT_SAMPLE: begin
        cmd.kind = CMD_SAMPLE;
        keep = int'(item.in_channel) < IN_CHANNELS;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = item.valid && item.ready && keep;
  assign head.valid = (count != '0);
  assign head.cmd = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/c1d_back.sv
// Back end: weight/bias stores, sample window and the shared multiply-accumulate.
// Depends on c1d_pkg, c1d_ram and c1d_res_if.
`default_nettype none
module c1d_back #(
  parameter int IN_CHANNELS  = 8,
  parameter int OUT_CHANNELS = 8,
  parameter int TAPS         = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  c1d_pkg::q_head_t head,
  output logic            pop,
  c1d_res_if.source       res
);
  import c1d_pkg::*;

  localparam int PAD   = TAPS / 2;
  localparam int WDEP  = OUT_CHANNELS * IN_CHANNELS * TAPS;
  localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int BAW   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int ICW   = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int KW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PSW   = $clog2(PAD + 2);

  state_t state, state_next;

  logic signed [VAL_W-1:0] win [TAPS][IN_CHANNELS];
  logic [BAW-1:0]  oc;
  logic [ICW-1:0]  ic;
  logic [KW-1:0]   k;
  logic [PSW-1:0]  ps;
  logic [PSW-1:0]  ps_inc;
  logic [PSW-1:0]  rem;
  logic            eos;
  logic signed [ACC_W-1:0] acc;
  logic signed [RES_W-1:0] prod;
  logic signed [VAL_W-1:0] sample_a;
  logic            valid_a;
  logic            valid_b;

  logic             w_we;
  logic [WAW-1:0]   w_waddr;
  logic [WAW-1:0]   w_raddr;
  logic [VAL_W-1:0] w_rdata;
  logic             b_we;
  logic [VAL_W-1:0] b_rdata;

  logic completes;
  logic emit;
  logic mac_last;
  logic out_load;
  logic oc_last;
  logic advance;
  logic signed [RES_W-1:0] sat;

  c1d_ram #(.WIDTH(VAL_W), .DEPTH(WDEP)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(head.cmd.value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  c1d_ram #(.WIDTH(VAL_W), .DEPTH(OUT_CHANNELS)) u_bram (
    .clk(clk), .we(b_we), .waddr(BAW'(head.cmd.out_channel)), .wdata(head.cmd.value),
    .raddr(oc), .rdata(b_rdata)
  );

  assign completes = (int'(head.cmd.in_channel) == IN_CHANNELS - 1) || head.cmd.eos;
  assign ps_inc    = (int'(ps) < PAD + 1) ? ps + 1'b1 : ps;
  assign emit      = int'(ps_inc) > PAD;
  assign mac_last  = (int'(k) == TAPS - 1) && (int'(ic) == IN_CHANNELS - 1);
  assign out_load  = (state == S_OUT) && (!res.valid || res.ready);
  assign oc_last   = int'(oc) == OUT_CHANNELS - 1;
  assign advance   = ((state == S_POS) && !emit) || (out_load && oc_last);

  always_comb begin
    if (acc[ACC_W-1] == 1'b0 && |acc[ACC_W-2:RES_W-1]) begin
      sat = {1'b0, {(RES_W-1){1'b1}}};
    end else if (acc[ACC_W-1] == 1'b1 && !(&acc[ACC_W-2:RES_W-1])) begin
      sat = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat = acc[RES_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head.valid && head.cmd.kind == CMD_SAMPLE && completes) begin
          state_next = S_POS;
        end
      end
      S_POS: begin
        if (emit) begin
          state_next = S_BIAS;
        end else if (rem == PSW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_BIAS: state_next = S_MAC;
      S_MAC: begin
        if (mac_last) begin
          state_next = S_D1;
        end
      end
      S_D1: state_next = S_D2;
      S_D2: state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          if (!oc_last) begin
            state_next = S_BIAS;
          end else if (rem == PSW'(1)) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_POS;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    w_we    = 1'b0;
    b_we    = 1'b0;
    w_waddr = WAW'((int'(head.cmd.out_channel) * IN_CHANNELS + int'(head.cmd.in_channel))
                   * TAPS + int'(head.cmd.tap));
    w_raddr = WAW'((int'(oc) * IN_CHANNELS + int'(ic)) * TAPS + int'(k));
    if (state == S_IDLE && head.valid) begin
      pop  = 1'b1;
      w_we = head.cmd.kind == CMD_WEIGHT;
      b_we = head.cmd.kind == CMD_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    sample_a <= win[k][ic];
    if (valid_a) begin
      prod <= sample_a * $signed(w_rdata);
    end
    if (state == S_MAC && k == '0 && ic == '0) begin
      acc <= {{(ACC_W-VAL_W-8){b_rdata[VAL_W-1]}}, b_rdata, 8'h00};
    end else if (valid_b) begin
      acc <= acc + {{(ACC_W-RES_W){prod[RES_W-1]}}, prod};
    end
    if (out_load) begin
      res.channel_out <= CH_W'(oc);
      res.result      <= sat;
      res.last        <= oc_last && (rem == PSW'(1));
    end
    case (state)
      S_IDLE: begin
        if (head.valid && head.cmd.kind == CMD_SAMPLE) begin
          rem <= head.cmd.eos ? PSW'(PAD + 1) : PSW'(1);
          eos <= head.cmd.eos;
        end
      end
      S_BIAS: begin
        k  <= '0;
        ic <= '0;
      end
      S_MAC: begin
        if (int'(ic) == IN_CHANNELS - 1) begin
          ic <= '0;
          k  <= k + 1'b1;
        end else begin
          ic <= ic + 1'b1;
        end
      end
      default: ;
    endcase
    if (state == S_POS) begin
      oc <= '0;
    end else if (out_load && !oc_last) begin
      oc <= oc + 1'b1;
    end
    if (advance) begin
      rem <= rem - 1'b1;
    end

    if (rst) begin
      state   <= S_IDLE;
      ps      <= '0;
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      res.valid <= 1'b0;
      for (int t = 0; t < TAPS; t++) begin
        for (int c = 0; c < IN_CHANNELS; c++) begin
          win[t][c] <= '0;
        end
      end
    end else begin
      state   <= state_next;
      valid_a <= state == S_MAC;
      valid_b <= valid_a;
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (state == S_POS) begin
        ps <= ps_inc;
      end
      if (state == S_IDLE && head.valid && head.cmd.kind == CMD_SAMPLE) begin
        win[TAPS-1][ICW'(head.cmd.in_channel)] <= head.cmd.value;
      end
      if (advance) begin
        if (rem == PSW'(1) && eos) begin
          ps <= '0;
          for (int t = 0; t < TAPS; t++) begin
            for (int c = 0; c < IN_CHANNELS; c++) begin
              win[t][c] <= '0;
            end
          end
        end else begin
          for (int t = 0; t < TAPS - 1; t++) begin
            for (int c = 0; c < IN_CHANNELS; c++) begin
              win[t][c] <= win[t+1][c];
            end
          end
          for (int c = 0; c < IN_CHANNELS; c++) begin
            win[TAPS-1][c] <= '0;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/conv1d_same_pad_forward.sv
// Multichannel 1D convolution, same zero padding, per-channel bias.
// Load and sample items are queued; a queue of 4 commands decouples the front.
// Each output channel passes through S_BIAS, S_MAC over every tap and input channel,
// S_D1, S_D2 and S_OUT on the one shared MAC; an emitting position does this for every output channel in turn.
// End of sequence adds up to TAPS/2 more such positions. Other items retire from S_IDLE.
// Synchronous reset clears the window, position count, queue and output; stores stay unset.
`default_nettype none
module conv1d_same_pad_forward #(
  parameter int IN_CHANNELS  = 8,
  parameter int OUT_CHANNELS = 8,
  parameter int TAPS         = 3
) (
  input wire logic  clk,
  input wire logic  rst,
  c1d_item_if.sink  item,
  c1d_res_if.source res
);
  import c1d_pkg::*;

  q_head_t head;
  logic    pop;

  c1d_front #(
    .IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS), .TAPS(TAPS)
  ) u_front (
    .clk(clk), .rst(rst), .item(item), .head(head), .pop(pop)
  );

  c1d_back #(
    .IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS), .TAPS(TAPS)
  ) u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .res(res)
  );
endmodule
`default_nettype wire

// File: hw/rtl/c1d_checker.sv
// Port-level checks for the convolution block, bound to the top level.
// Depends on conv1d_same_pad_forward_defines.svh.
`default_nettype none
`include "conv1d_same_pad_forward_defines.svh"
module c1d_checker #(
  parameter int OUT_CHANNELS = 8
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [2:0] res_channel_out,
  input wire logic       res_last
);
  `C1D_ASSERT_NEXT_RST(a_reset_idle, rst, !res_valid)
  `C1D_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid)
  `C1D_ASSERT_NOW(a_last_chan, res_valid && res_last, res_channel_out == 3'(OUT_CHANNELS - 1))
endmodule

bind conv1d_same_pad_forward c1d_checker #(.OUT_CHANNELS(OUT_CHANNELS)) u_c1d_checker (
  .clk(clk), .rst(rst), .res_valid(res.valid), .res_ready(res.ready),
  .res_channel_out(res.channel_out), .res_last(res.last)
);
`default_nettype wire
